>>> src/particle_contact_counter_unit_macros.svh
// Assertion macros for the particle contact counter unit.
// Included by the controller and the datapath; depends on nothing else.
// The macros expect aclk and aresetn to be visible where they are used.
`ifndef PARTICLE_CONTACT_COUNTER_UNIT_MACROS_SVH
`define PARTICLE_CONTACT_COUNTER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every clock edge outside reset.
`define PCC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define PCC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCC_ASSERT_IMP(name, ante, cons, msg)
`define PCC_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

>>> src/pcc_pkg.sv
// Shared types and constants of the particle contact counter unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 10;
    localparam int RADIUS_W   = 24;
    localparam int SKIN_W     = 23;
    localparam int RAD_SUM_W  = 25;
    localparam int COUNT_W    = 16;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 23;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PAIR  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SKIN_DISTANCE  = 1'd0,
        REG_HISTORY_ENABLE = 1'd1
    } cfg_reg_t;

    // Operand chosen for the shared squaring multiplier.
    typedef enum logic [1:0] {
        OPS_DX  = 2'd0,
        OPS_DY  = 2'd1,
        OPS_DZ  = 2'd2,
        OPS_RAD = 2'd3
    } opsel_t;

    typedef struct packed {
        logic   load_item;
        logic   mul_en;
        opsel_t mul_sel;
        logic   touch_load;
        logic   mem_rd;
        logic   mem_wr;
        logic   mem_sec;
        logic   wr_clear;
        logic   out_load;
    } pcc_cmd_t;

    typedef struct packed {
        action_t new_action;
        logic    touch;
        logic    out_free;
    } pcc_status_t;

endpackage

>>> src/pcc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the contact count table; depends on nothing.
`timescale 1ns / 1ps

module pcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pcc_ctrl.sv
// Controller state machine of the particle contact counter unit.
// Depends on pcc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "particle_contact_counter_unit_macros.svh"

module pcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pcc_pkg::pcc_status_t status,
    output pcc_pkg::pcc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_MUL,
        ST_SUM,
        ST_CMP,
        ST_RD,
        ST_WR,
        ST_RDQ,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] cnt_reg;
    logic       sec_reg;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sec_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    sec_reg <= 1'b0;
                    if (accept) begin
                        case (status.new_action)
                            pcc_pkg::ACT_CLEAR: state_reg <= ST_CLR;
                            pcc_pkg::ACT_PAIR:  state_reg <= ST_MUL;
                            pcc_pkg::ACT_READ:  state_reg <= ST_RDQ;
                            default:            state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CLR: state_reg <= ST_DONE;
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (pcc_pkg::opsel_t'(cnt_reg) == pcc_pkg::OPS_RAD) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: state_reg <= ST_CMP;
                ST_CMP: begin
                    sec_reg   <= 1'b0;
                    state_reg <= status.touch ? ST_RD : ST_DONE;
                end
                ST_RD: state_reg <= ST_WR;
                ST_WR: begin
                    if (sec_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        sec_reg   <= 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_RDQ: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.load_item  = accept;
        cmd.mul_sel    = pcc_pkg::opsel_t'(cnt_reg);
        cmd.mem_sec    = sec_reg;
        case (state_reg)
            ST_CLR: begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_clear = 1'b1;
            end
            ST_MUL:  cmd.mul_en     = 1'b1;
            ST_CMP:  cmd.touch_load = 1'b1;
            ST_RD:   cmd.mem_rd     = 1'b1;
            ST_WR:   cmd.mem_wr     = 1'b1;
            ST_RDQ:  cmd.mem_rd     = 1'b1;
            ST_DONE: cmd.out_load   = status.out_free;
            default: cmd.out_load   = 1'b0;
        endcase
    end

    `PCC_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "accepted item left controller idle")
    `PCC_ASSERT_IMP(a_bump_needs_touch, state_reg == ST_WR, status.touch, "count bumped without contact")

endmodule

>>> src/pcc_datapath.sv
// Datapath of the particle contact counter unit: item registers, the shared
// squaring multiplier, the count memory and the output register.
// Depends on pcc_pkg, pcc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "particle_contact_counter_unit_macros.svh"

module pcc_datapath #(
    parameter int NUM_PARTICLES = 1024,
    parameter int POS_BITS      = 24,
    localparam int IN_FIELDS_W  = 2 * pcc_pkg::INDEX_W + 6 * POS_BITS + pcc_pkg::RADIUS_W + 2,
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [IN_DATA_W-1:0]              s_tdata,
    input  logic [pcc_pkg::ACTION_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  pcc_pkg::pcc_cmd_t                 cmd,
    output pcc_pkg::pcc_status_t              status
);

    localparam int ADDR_W    = $clog2(NUM_PARTICLES);
    localparam int IDX_EXT_W = (ADDR_W > pcc_pkg::INDEX_W) ? ADDR_W : pcc_pkg::INDEX_W;
    localparam int DIFF_W    = POS_BITS + 1;
    localparam int OP_W      = (DIFF_W > pcc_pkg::RAD_SUM_W + 1) ? DIFF_W
                                                                  : pcc_pkg::RAD_SUM_W + 1;
    localparam int PROD_W    = 2 * OP_W;
    localparam int ACC_W     = PROD_W + 2;

    localparam int OFF_FI     = 0;
    localparam int OFF_SI     = pcc_pkg::INDEX_W;
    localparam int OFF_FX     = 2 * pcc_pkg::INDEX_W;
    localparam int OFF_FY     = OFF_FX + POS_BITS;
    localparam int OFF_FZ     = OFF_FY + POS_BITS;
    localparam int OFF_SX     = OFF_FZ + POS_BITS;
    localparam int OFF_SY     = OFF_SX + POS_BITS;
    localparam int OFF_SZ     = OFF_SY + POS_BITS;
    localparam int OFF_RAD    = OFF_SZ + POS_BITS;
    localparam int OFF_STORED = OFF_RAD + pcc_pkg::RADIUS_W;
    localparam int OFF_GROUP  = OFF_STORED + 1;

    // Configuration registers.
    logic [pcc_pkg::SKIN_W-1:0] skin_reg;
    logic                       hist_reg;

    // Item registers.
    pcc_pkg::action_t                action_reg;
    logic [pcc_pkg::INDEX_W-1:0]     fi_reg;
    logic [pcc_pkg::INDEX_W-1:0]     si_reg;
    logic signed [DIFF_W-1:0]        dx_reg;
    logic signed [DIFF_W-1:0]        dy_reg;
    logic signed [DIFF_W-1:0]        dz_reg;
    logic [pcc_pkg::RAD_SUM_W-1:0]   radsum_reg;
    logic                            stored_reg;
    logic                            group_reg;

    // Squaring pipeline.
    logic signed [OP_W-1:0]   op;
    logic signed [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0]        prod_reg;
    pcc_pkg::opsel_t          prod_sel_reg;
    logic                     prod_vld_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [PROD_W-1:0]        radsq_reg;
    logic                     geom;
    logic                     touch_now;
    logic                     touch_reg;

    // Count memory.
    logic [IDX_EXT_W-1:0]       fi_ext;
    logic [IDX_EXT_W-1:0]       si_ext;
    logic                       fi_in_range;
    logic                       si_in_range;
    logic [ADDR_W-1:0]          mem_addr;
    logic                       mem_in_range;
    logic [pcc_pkg::COUNT_W-1:0] rd_data;
    logic [pcc_pkg::COUNT_W-1:0] wr_data;

    // Output register.
    logic                        m_valid_reg;
    logic                        m_touch_reg;
    logic [pcc_pkg::COUNT_W-1:0] m_count_reg;
    logic [pcc_pkg::COUNT_W-1:0] count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skin_reg <= '0;
            hist_reg <= 1'b0;
        end else if (cfg_we) begin
            case (pcc_pkg::cfg_reg_t'(cfg_addr))
                pcc_pkg::REG_SKIN_DISTANCE:  skin_reg <= cfg_wdata;
                pcc_pkg::REG_HISTORY_ENABLE: hist_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Differences and the padded radius sum are formed as the item is taken.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= pcc_pkg::action_t'(s_tuser);
            fi_reg     <= s_tdata[OFF_FI +: pcc_pkg::INDEX_W];
            si_reg     <= s_tdata[OFF_SI +: pcc_pkg::INDEX_W];
            dx_reg     <= DIFF_W'($signed(s_tdata[OFF_FX +: POS_BITS]))
                        - DIFF_W'($signed(s_tdata[OFF_SX +: POS_BITS]));
            dy_reg     <= DIFF_W'($signed(s_tdata[OFF_FY +: POS_BITS]))
                        - DIFF_W'($signed(s_tdata[OFF_SY +: POS_BITS]));
            dz_reg     <= DIFF_W'($signed(s_tdata[OFF_FZ +: POS_BITS]))
                        - DIFF_W'($signed(s_tdata[OFF_SZ +: POS_BITS]));
            radsum_reg <= pcc_pkg::RAD_SUM_W'(s_tdata[OFF_RAD +: pcc_pkg::RADIUS_W])
                        + pcc_pkg::RAD_SUM_W'(skin_reg);
            stored_reg <= s_tdata[OFF_STORED];
            group_reg  <= s_tdata[OFF_GROUP];
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            pcc_pkg::OPS_DX:  op = OP_W'(dx_reg);
            pcc_pkg::OPS_DY:  op = OP_W'(dy_reg);
            pcc_pkg::OPS_DZ:  op = OP_W'(dz_reg);
            pcc_pkg::OPS_RAD: op = $signed(OP_W'(radsum_reg));
            default:          op = '0;
        endcase
    end

    assign prod_next = op * op;

    always_ff @(posedge aclk) begin
        prod_reg     <= PROD_W'(unsigned'(prod_next));
        prod_sel_reg <= cmd.mul_sel;
        if (cmd.load_item) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            if (prod_sel_reg == pcc_pkg::OPS_RAD) begin
                radsq_reg <= prod_reg;
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            touch_reg    <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
            if (cmd.load_item) begin
                touch_reg <= 1'b0;
            end else if (cmd.touch_load) begin
                touch_reg <= touch_now;
            end
        end
    end

    assign geom      = (acc_reg <= ACC_W'(radsq_reg));
    assign touch_now = group_reg && (geom || (hist_reg && stored_reg));

    assign fi_ext       = IDX_EXT_W'(fi_reg);
    assign si_ext       = IDX_EXT_W'(si_reg);
    assign fi_in_range  = (32'(fi_reg) < 32'(NUM_PARTICLES));
    assign si_in_range  = (32'(si_reg) < 32'(NUM_PARTICLES));
    assign mem_addr     = cmd.mem_sec ? si_ext[ADDR_W-1:0] : fi_ext[ADDR_W-1:0];
    assign mem_in_range = cmd.mem_sec ? si_in_range : fi_in_range;

    // Clear to zero, or increment with saturation at the top of the count range.
    assign wr_data = cmd.wr_clear ? '0
                   : (rd_data == pcc_pkg::COUNT_MAX) ? rd_data
                   : rd_data + pcc_pkg::COUNT_W'(1);

    pcc_ram #(
        .WIDTH (pcc_pkg::COUNT_W),
        .DEPTH (NUM_PARTICLES)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cmd.mem_wr && mem_in_range),
        .wr_addr (mem_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.mem_rd),
        .rd_addr (mem_addr),
        .rd_data (rd_data)
    );

    assign count_next = ((action_reg == pcc_pkg::ACT_READ) && fi_in_range) ? rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_touch_reg <= touch_reg;
            m_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pcc_pkg::OUT_DATA_W - pcc_pkg::COUNT_W - 1){1'b0}},
                       m_count_reg, m_touch_reg};

    assign status.new_action = pcc_pkg::action_t'(s_tuser);
    assign status.touch      = touch_now;
    assign status.out_free   = !m_valid_reg || m_tready;

    `PCC_ASSERT_IMP(a_load_into_free_slot, cmd.out_load, !m_valid_reg || m_tready, "result overwrote a waiting result")
    `PCC_ASSERT_NXT(a_count_only_on_read, cmd.out_load && (action_reg != pcc_pkg::ACT_READ), m_count_reg == '0, "non-read item returned a count")

endmodule

>>> src/particle_contact_counter_unit.sv
// Top level of the particle contact counter unit.
// Depends on pcc_pkg, pcc_ctrl, pcc_datapath (with pcc_ram) and the macro header.
`timescale 1ns / 1ps

// The unit keeps a table of saturating 16-bit contact counts, one per particle,
// and takes one item at a time: a clear item zeroes an entry, a read item
// returns an entry, and a pair item tests two particles for contact and, when
// they touch and the in_group bit is set, adds one to both counts.
// Every item gives exactly one result. A pair item uses the single squaring
// multiplier four times in turn (the three coordinate differences and the
// radius sum plus skin), and the count memory has one port each way, so each
// of the two counts is bumped by a read followed by a write. The next item is
// taken in the cycle after the result is loaded into the output register,
// even while that result still waits for m_tready. Counts are undefined after
// reset: clear an entry before it is read or counted. There is no clearing
// pass after reset.
module particle_contact_counter_unit #(
    parameter int NUM_PARTICLES = 1024,
    parameter int POS_BITS      = 24,
    localparam int IN_FIELDS_W  = 2 * pcc_pkg::INDEX_W + 6 * POS_BITS + pcc_pkg::RADIUS_W + 2,
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Register writes: index 0 is skin_distance, index 1 is history_enable.
    input  logic                           cfg_we,
    input  logic [pcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0: first_index, second_index, first_x, first_y, first_z,
    // second_x, second_y, second_z, radius_sum_in, stored_contact, in_group,
    // then zero fill to a whole byte.
    input  logic [IN_DATA_W-1:0]           s_tdata,
    // action: 0 clear, 1 pair test, 2 read.
    input  logic [pcc_pkg::ACTION_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0: touching, count_value, then zero fill.
    output logic [pcc_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Commands from the controller and status back from the datapath are the
    // only connection between the two halves.
    pcc_pkg::pcc_cmd_t    cmd;
    pcc_pkg::pcc_status_t status;

    pcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the item registers, the
    // squaring pipeline, the count memory and the output register.
    pcc_datapath #(
        .NUM_PARTICLES (NUM_PARTICLES),
        .POS_BITS      (POS_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
